// ===== rtl/lcdc_pkg.sv =====
// shared types and constants of the lcd controller command and data path
package lcdc_pkg;

  localparam logic [7:0] CMD_SOFT_RESET  = 8'h01;
  localparam logic [7:0] CMD_INV_OFF     = 8'h20;
  localparam logic [7:0] CMD_INV_ON      = 8'h21;
  localparam logic [7:0] CMD_DISP_OFF    = 8'h28;
  localparam logic [7:0] CMD_DISP_ON     = 8'h29;
  localparam logic [7:0] CMD_COL_WIN     = 8'h2A;
  localparam logic [7:0] CMD_ROW_WIN     = 8'h2B;
  localparam logic [7:0] CMD_MEM_WRITE   = 8'h2C;
  localparam logic [7:0] CMD_COLOUR_MODE = 8'h3A;

  localparam logic [2:0] MODE_12BIT = 3'd3;
  localparam logic [2:0] MODE_16BIT = 3'd5;
  localparam logic [2:0] MODE_18BIT = 3'd6;

  localparam logic       OP_COMMAND = 1'b0;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    ENT_PIXEL,
    ENT_COL_WIN,
    ENT_ROW_WIN,
    ENT_CUR_RESET
  } ent_kind_t;

  typedef struct packed {
    ent_kind_t  kind;
    logic       two_pix;
    logic [7:0] r0;
    logic [7:0] g0;
    logic [7:0] b0;
    logic [7:0] r1;
    logic [7:0] g1;
    logic [7:0] b1;
    logic       inv;
    logic       disp;
    logic [7:0] win_first;
    logic [7:0] win_last;
  } q_entry_t;

  typedef struct packed {
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       on_panel;
    logic       inv;
    logic       disp;
    logic       last;
  } pix_out_t;

endpackage

// ===== rtl/lcdc_front.sv =====
// front end: command decode, parameter collection and pixel packing
module lcdc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_op,
  input  logic [7:0]        in_byte,
  input  logic              q_full,
  output logic              q_push,
  output lcdc_pkg::q_entry_t q_data
);
  import lcdc_pkg::*;

  logic [2:0] colour_mode, colour_mode_next;
  logic       invert_flag, invert_flag_next;
  logic       display_flag, display_flag_next;
  logic [7:0] pending_command, pending_command_next;
  logic [2:0] param_index, param_index_next;
  logic [7:0] param_bytes [4];
  logic [7:0] param_bytes_next [4];
  logic [7:0] pixel_bytes [3];
  logic [7:0] pixel_bytes_next [3];
  logic [1:0] pixel_byte_index, pixel_byte_index_next;

  logic       accept;
  logic [7:0] pb_m [3];
  logic [1:0] idx_inc;
  q_entry_t   ent;
  logic       push;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pb_m[i] = (pixel_byte_index == 2'(i)) ? in_byte : pixel_bytes[i];
    end
  end

  assign idx_inc = pixel_byte_index + 2'd1;

  always_comb begin
    colour_mode_next      = colour_mode;
    invert_flag_next      = invert_flag;
    display_flag_next     = display_flag;
    pending_command_next  = pending_command;
    param_index_next      = param_index;
    param_bytes_next      = param_bytes;
    pixel_bytes_next      = pixel_bytes;
    pixel_byte_index_next = pixel_byte_index;
    push                  = 1'b0;
    ent                   = '0;
    ent.inv               = invert_flag;
    ent.disp              = display_flag;
    if (in_op == OP_COMMAND) begin
      unique case (in_byte)
        CMD_INV_OFF:  invert_flag_next = 1'b0;
        CMD_INV_ON:   invert_flag_next = 1'b1;
        CMD_DISP_ON:  display_flag_next = 1'b1;
        CMD_DISP_OFF: display_flag_next = 1'b0;
        CMD_SOFT_RESET: begin
          colour_mode_next  = MODE_18BIT;
          invert_flag_next  = 1'b0;
          display_flag_next = 1'b0;
          ent.kind          = ENT_CUR_RESET;
          push              = 1'b1;
        end
        default: begin
          pending_command_next = in_byte;
          param_index_next     = 3'd0;
        end
      endcase
    end else if (pending_command == CMD_MEM_WRITE) begin
      pixel_bytes_next      = pb_m;
      pixel_byte_index_next = idx_inc;
      ent.kind              = ENT_PIXEL;
      if (colour_mode == MODE_16BIT && idx_inc >= 2'd2) begin
        ent.r0                = {pb_m[0][7:3], 3'b000};
        ent.g0                = {pb_m[0][2:0], pb_m[1][7:5], 2'b00};
        ent.b0                = {pb_m[1][4:0], 3'b000};
        push                  = 1'b1;
        pixel_byte_index_next = 2'd0;
      end else if (idx_inc == 2'd3) begin
        if (colour_mode == MODE_18BIT) begin
          ent.r0 = {pb_m[0][7:2], 2'b00};
          ent.g0 = {pb_m[1][7:2], 2'b00};
          ent.b0 = {pb_m[2][7:2], 2'b00};
          push   = 1'b1;
        end else if (colour_mode == MODE_12BIT) begin
          ent.two_pix = 1'b1;
          ent.r0      = {pb_m[0][7:4], 4'h0};
          ent.g0      = {pb_m[0][3:0], 4'h0};
          ent.b0      = {pb_m[1][7:4], 4'h0};
          ent.r1      = {pb_m[1][3:0], 4'h0};
          ent.g1      = {pb_m[2][7:4], 4'h0};
          ent.b1      = {pb_m[2][3:0], 4'h0};
          push        = 1'b1;
        end
        pixel_byte_index_next = 2'd0;
      end
    end else begin
      if (param_index < 3'd4) begin
        param_bytes_next[param_index[1:0]] = in_byte;
        param_index_next = param_index + 3'd1;
      end
      if (pending_command == CMD_COL_WIN && param_index_next == 3'd4) begin
        ent.kind             = ENT_COL_WIN;
        ent.win_first        = param_bytes_next[1];
        ent.win_last         = param_bytes_next[3];
        push                 = 1'b1;
        pending_command_next = 8'h00;
        param_index_next     = 3'd0;
      end else if (pending_command == CMD_ROW_WIN && param_index_next == 3'd4) begin
        ent.kind             = ENT_ROW_WIN;
        ent.win_first        = param_bytes_next[1];
        ent.win_last         = param_bytes_next[3];
        push                 = 1'b1;
        pending_command_next = 8'h00;
        param_index_next     = 3'd0;
      end else if (pending_command == CMD_COLOUR_MODE && param_index_next == 3'd1) begin
        if (param_bytes_next[0] == {5'd0, MODE_12BIT} ||
            param_bytes_next[0] == {5'd0, MODE_16BIT} ||
            param_bytes_next[0] == {5'd0, MODE_18BIT}) begin
          colour_mode_next = param_bytes_next[0][2:0];
        end
        pending_command_next = 8'h00;
        param_index_next     = 3'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      colour_mode      <= MODE_18BIT;
      invert_flag      <= 1'b0;
      display_flag     <= 1'b0;
      pending_command  <= 8'h00;
      param_index      <= 3'd0;
      pixel_byte_index <= 2'd0;
    end else if (accept) begin
      colour_mode      <= colour_mode_next;
      invert_flag      <= invert_flag_next;
      display_flag     <= display_flag_next;
      pending_command  <= pending_command_next;
      param_index      <= param_index_next;
      pixel_byte_index <= pixel_byte_index_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      param_bytes <= param_bytes_next;
      pixel_bytes <= pixel_bytes_next;
    end
  end

  assign q_push = accept && push;
  assign q_data = ent;

endmodule

// ===== rtl/lcdc_queue.sv =====
// short queue of decoded work between front and back
module lcdc_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  lcdc_pkg::q_entry_t push_data,
  input  logic               pop,
  output lcdc_pkg::q_entry_t head,
  output logic               not_empty,
  output logic               full
);
  import lcdc_pkg::*;

  localparam int PtrW = $clog2(QUEUE_DEPTH);

  q_entry_t          mem [QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr, rd_ptr;
  logic [PtrW:0]     count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PtrW'(1);
      if (pop) rd_ptr <= rd_ptr + PtrW'(1);
      count <= count + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  assign head      = mem[rd_ptr];
  assign not_empty = (count != '0);
  assign full      = (count == (PtrW+1)'(QUEUE_DEPTH));

endmodule

// ===== rtl/lcdc_back.sv =====
// back end: window and cursor tracking, pixel emission into the output register
module lcdc_back #(
  parameter int PANEL_WIDTH  = 160,
  parameter int PANEL_HEIGHT = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  lcdc_pkg::q_entry_t head,
  input  logic               head_valid,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output lcdc_pkg::pix_out_t out_pix
);
  import lcdc_pkg::*;

  logic [7:0] window_x_first, window_x_first_next;
  logic [7:0] window_x_last, window_x_last_next;
  logic [7:0] window_y_first, window_y_first_next;
  logic [7:0] window_y_last, window_y_last_next;
  logic [7:0] column_cursor, column_cursor_next;
  logic [7:0] row_cursor, row_cursor_next;
  logic       sub, sub_next;
  logic       out_valid_next;
  pix_out_t   out_pix_next;
  logic       load;

  logic       out_free;
  logic [7:0] col_inc, col_adv, row_mid, row_adv;
  logic       last_pix;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    col_inc = column_cursor + 8'd1;
    if (col_inc > window_x_last) begin
      col_adv = window_x_first;
      row_mid = row_cursor + 8'd1;
    end else begin
      col_adv = col_inc;
      row_mid = row_cursor;
    end
    row_adv = (row_mid > window_y_last) ? window_y_first : row_mid;
  end

  assign last_pix = !head.two_pix || sub;

  always_comb begin
    window_x_first_next = window_x_first;
    window_x_last_next  = window_x_last;
    window_y_first_next = window_y_first;
    window_y_last_next  = window_y_last;
    column_cursor_next  = column_cursor;
    row_cursor_next     = row_cursor;
    sub_next            = sub;
    pop                 = 1'b0;
    load                = 1'b0;
    out_pix_next.x        = column_cursor;
    out_pix_next.y        = row_cursor;
    out_pix_next.r        = sub ? head.r1 : head.r0;
    out_pix_next.g        = sub ? head.g1 : head.g0;
    out_pix_next.b        = sub ? head.b1 : head.b0;
    out_pix_next.on_panel = ({1'b0, column_cursor} < 9'(PANEL_WIDTH)) &&
                            ({1'b0, row_cursor} < 9'(PANEL_HEIGHT));
    out_pix_next.inv      = head.inv;
    out_pix_next.disp     = head.disp;
    out_pix_next.last     = last_pix;
    if (head_valid) begin
      unique case (head.kind)
        ENT_PIXEL: begin
          if (out_free) begin
            load               = 1'b1;
            column_cursor_next = col_adv;
            row_cursor_next    = row_adv;
            if (last_pix) begin
              pop      = 1'b1;
              sub_next = 1'b0;
            end else begin
              sub_next = 1'b1;
            end
          end
        end
        ENT_COL_WIN: begin
          window_x_first_next = head.win_first;
          window_x_last_next  = head.win_last;
          column_cursor_next  = head.win_first;
          pop                 = 1'b1;
        end
        ENT_ROW_WIN: begin
          window_y_first_next = head.win_first;
          window_y_last_next  = head.win_last;
          row_cursor_next     = head.win_first;
          pop                 = 1'b1;
        end
        ENT_CUR_RESET: begin
          column_cursor_next = 8'd0;
          row_cursor_next    = 8'd0;
          pop                = 1'b1;
        end
        default: pop = 1'b0;
      endcase
    end
    out_valid_next = out_free ? load : out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_x_first <= 8'd0;
      window_x_last  <= 8'd0;
      window_y_first <= 8'd0;
      window_y_last  <= 8'd0;
      column_cursor  <= 8'd0;
      row_cursor     <= 8'd0;
      sub            <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      window_x_first <= window_x_first_next;
      window_x_last  <= window_x_last_next;
      window_y_first <= window_y_first_next;
      window_y_last  <= window_y_last_next;
      column_cursor  <= column_cursor_next;
      row_cursor     <= row_cursor_next;
      sub            <= sub_next;
      out_valid      <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_pix <= out_pix_next;
  end

endmodule

// ===== rtl/lcd_controller_command_data_path_core.sv =====
// top level of the lcd controller command and data path
// path: a byte that finishes a pixel is written into the work queue, then loaded into the output register on m_axis
// throughput: one byte per cycle; a byte that finishes two pixels gives two output beats, tlast low on the first
// the input stalls only while the four-entry work queue is full
// reset: synchronous, clears modes, flags, window, cursors and queue; byte stores keep contents
module lcd_controller_command_data_path_core #(
  parameter int PANEL_WIDTH  = 160,
  parameter int PANEL_HEIGHT = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // byte_value
  input  logic [0:0]  s_axis_tuser,  // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // pixel_x, pixel_y, red, green, blue
  output logic [2:0]  m_axis_tuser,  // on_panel, inverted_now, display_enabled
  output logic        m_axis_tlast   // last_of_run
);
  import lcdc_pkg::*;

  q_entry_t q_push_data;
  q_entry_t q_head;
  logic     q_push;
  logic     q_pop;
  logic     q_not_empty;
  logic     q_full;
  pix_out_t out_pix;

  lcdc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_op    (s_axis_tuser[0]),
    .in_byte  (s_axis_tdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_push_data)
  );

  lcdc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  lcdc_back #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .head_valid (q_not_empty),
    .pop        (q_pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_pix    (out_pix)
  );

  assign m_axis_tdata = {out_pix.b, out_pix.g, out_pix.r, out_pix.y, out_pix.x};
  assign m_axis_tuser = {out_pix.disp, out_pix.inv, out_pix.on_panel};
  assign m_axis_tlast = out_pix.last;

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_not_empty)
    else $error("queue popped while empty");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !q_push)
    else $error("queue pushed while full");

  a_second_pixel_follows: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
    else $error("second pixel of a byte did not follow");

  a_reset_clears_output: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule
